/* hdl/rld_pkg.sv */
package rld_pkg;

    // controller states
    typedef enum logic [0:0] {
        ST_TAKE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    // decoder position within the encoded stream
    typedef enum logic [1:0] {
        MODE_LEN = 2'd0,
        MODE_LIT = 2'd1,
        MODE_REP = 2'd2,
        MODE_EOD = 2'd3
    } t_mode;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_DATA  = 2'd0,
        STATUS_EOD   = 2'd1,
        STATUS_CLEAN = 2'd2,
        STATUS_TRUNC = 2'd3
    } t_status;

    // length byte that marks end of data
    localparam logic [7:0] EOD_CODE = 8'd128;
    // repeat count is REP_BASE minus the length byte
    localparam logic [8:0] REP_BASE = 9'd257;
    // decoded bytes carried by one full result
    localparam logic [7:0] CHUNK = 8'd2;

    typedef struct packed {
        logic take;   // accept the input byte this cycle
        logic step;   // emit one chunk of the current repeat run
    } t_cmd;

    typedef struct packed {
        logic out_free;   // output register can be loaded this cycle
        logic mode_rep;   // next input byte is a repeat byte
        logic run_final;  // next chunk finishes the repeat run
    } t_dp_status;

endpackage

/* hdl/rld_ctrl.sv */
module rld_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  rld_pkg::t_dp_status   i_stat,
    output rld_pkg::t_cmd         o_cmd,
    output logic                  o_in_ready
);

    rld_pkg::t_state r_state;
    rld_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rld_pkg::ST_TAKE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            rld_pkg::ST_TAKE: begin
                o_in_ready = i_stat.out_free;
                o_cmd.take = i_in_valid && i_stat.out_free;
                if (o_cmd.take && i_stat.mode_rep) begin
                    n_state = rld_pkg::ST_RUN;
                end
            end
            rld_pkg::ST_RUN: begin
                o_cmd.step = i_stat.out_free;
                if (o_cmd.step && i_stat.run_final) begin
                    n_state = rld_pkg::ST_TAKE;
                end
            end
            default: begin
                n_state = rld_pkg::ST_TAKE;
            end
        endcase
    end

endmodule

/* hdl/rld_datapath.sv */
module rld_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rld_pkg::t_cmd         i_cmd,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_in_last,
    input  logic                  i_out_ready,
    output rld_pkg::t_dp_status   o_stat,
    output logic                  o_out_valid,
    output logic [7:0]            o_out_byte_a,
    output logic [7:0]            o_out_byte_b,
    output logic [1:0]            o_out_count,
    output logic                  o_run_last,
    output logic [1:0]            o_status
);

    rld_pkg::t_mode   r_mode, n_mode;
    logic [7:0]       r_rem, n_rem;
    logic [7:0]       r_rep_byte, n_rep_byte;
    logic             r_rep_last, n_rep_last;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_a, n_out_a;
    logic [7:0]       r_out_b, n_out_b;
    logic [1:0]       r_out_count, n_out_count;
    logic             r_out_run_last, n_out_run_last;
    rld_pkg::t_status r_out_status, n_out_status;

    logic             ld;
    logic [7:0]       lit_rem;
    logic [7:0]       chunk;
    logic [7:0]       rem_after;
    logic [8:0]       rep_len;

    assign rep_len = rld_pkg::REP_BASE - {1'b0, i_in_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= rld_pkg::MODE_LEN;
            r_rem       <= '0;
            r_rep_last  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_rem       <= n_rem;
            r_rep_last  <= n_rep_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rep_byte     <= n_rep_byte;
        r_out_a        <= n_out_a;
        r_out_b        <= n_out_b;
        r_out_count    <= n_out_count;
        r_out_run_last <= n_out_run_last;
        r_out_status   <= n_out_status;
    end

    always_comb begin
        n_mode         = r_mode;
        n_rem          = r_rem;
        n_rep_byte     = r_rep_byte;
        n_rep_last     = r_rep_last;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_out_a        = r_out_a;
        n_out_b        = r_out_b;
        n_out_count    = r_out_count;
        n_out_run_last = r_out_run_last;
        n_out_status   = r_out_status;
        ld             = 1'b0;
        lit_rem        = r_rem - {7'd0, (r_rem != 8'd0)};
        chunk          = (r_rem >= rld_pkg::CHUNK) ? rld_pkg::CHUNK : 8'd1;
        rem_after      = r_rem - chunk;

        if (i_cmd.take) begin
            n_out_a      = '0;
            n_out_b      = '0;
            n_out_count  = '0;
            n_out_status = rld_pkg::STATUS_DATA;
            unique case (r_mode)
                rld_pkg::MODE_LEN: begin
                    if (i_in_byte < rld_pkg::EOD_CODE) begin
                        n_mode = rld_pkg::MODE_LIT;
                        n_rem  = i_in_byte + 8'd1;
                    end else if (i_in_byte > rld_pkg::EOD_CODE) begin
                        n_mode = rld_pkg::MODE_REP;
                        n_rem  = rep_len[7:0];
                    end else begin
                        n_mode       = rld_pkg::MODE_EOD;
                        n_rem        = '0;
                        ld           = 1'b1;
                        n_out_status = rld_pkg::STATUS_EOD;
                    end
                end
                rld_pkg::MODE_LIT: begin
                    ld          = 1'b1;
                    n_out_a     = i_in_byte;
                    n_out_count = 2'd1;
                    n_rem       = lit_rem;
                    if (lit_rem == 8'd0) begin
                        n_mode = rld_pkg::MODE_LEN;
                    end
                end
                rld_pkg::MODE_REP: begin
                    // results follow in the run state
                    n_rep_byte = i_in_byte;
                    n_rep_last = i_in_last;
                end
                rld_pkg::MODE_EOD: begin
                    // skip bytes until the source ends
                end
                default: begin
                    n_mode = rld_pkg::MODE_LEN;
                end
            endcase
            // source end outside a repeat run closes here
            if (i_in_last && r_mode != rld_pkg::MODE_REP) begin
                ld = 1'b1;
                if (n_rem != 8'd0 &&
                    (n_mode == rld_pkg::MODE_LIT || n_mode == rld_pkg::MODE_REP)) begin
                    n_out_status = rld_pkg::STATUS_TRUNC;
                end else begin
                    n_out_status = rld_pkg::STATUS_CLEAN;
                end
                n_mode = rld_pkg::MODE_LEN;
                n_rem  = '0;
            end
            if (ld) begin
                n_out_valid    = 1'b1;
                n_out_run_last = 1'b1;
            end
        end else if (i_cmd.step) begin
            n_out_valid    = 1'b1;
            n_out_a        = r_rep_byte;
            n_out_b        = (chunk == rld_pkg::CHUNK) ? r_rep_byte : 8'd0;
            n_out_count    = chunk[1:0];
            n_out_run_last = (rem_after == 8'd0);
            n_out_status   = (rem_after == 8'd0 && r_rep_last) ?
                             rld_pkg::STATUS_CLEAN : rld_pkg::STATUS_DATA;
            n_rem          = rem_after;
            if (rem_after == 8'd0) begin
                n_mode     = rld_pkg::MODE_LEN;
                n_rep_last = 1'b0;
            end
        end
    end

    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.mode_rep  = (r_mode == rld_pkg::MODE_REP);
    assign o_stat.run_final = (r_rem <= rld_pkg::CHUNK);

    assign o_out_valid  = r_out_valid;
    assign o_out_byte_a = r_out_a;
    assign o_out_byte_b = r_out_b;
    assign o_out_count  = r_out_count;
    assign o_run_last   = r_out_run_last;
    assign o_status     = r_out_status;

endmodule

/* hdl/run_length_decoder.sv */
// run-length decoder for the classic page-description-language scheme
//
// input channel: one encoded byte per transfer (i_in_byte) with i_in_last
// marking the final byte of the source. output channel: one result per
// transfer with up to two decoded bytes, their count, a flag on the last
// result that an input byte caused, and a status code (data, end-of-data
// marker, clean source end, truncated run).
//
// results are registered: each lands in the output register at the clock edge
// of the input transfer or run step that makes it. throughput: length and
// literal bytes go at one per cycle while the output register is free. a
// repeat byte holds the input until its run, n bytes long (2 to 128), has
// gone out, as the controller walks the run one two-byte chunk per cycle,
// odd tail alone, through the single output register while it is free.
//
// reset: synchronous, active low; the decoder returns to expecting a length
// byte and the output register empties. a stalled receiver holds the output
// register, which stops the run sequencer and drops o_in_ready, so nothing
// is lost; input is taken again the cycle the output register frees up.
module run_length_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte_a,
    output logic [7:0] o_out_byte_b,
    output logic [1:0] o_out_count,
    output logic       o_run_last,
    output logic [1:0] o_status
);

    // command and status between sequencer and datapath
    rld_pkg::t_cmd       w_cmd;
    rld_pkg::t_dp_status w_stat;

    // sequencer: takes bytes, walks repeat runs
    rld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (o_in_ready)
    );

    // datapath: decoder mode, run counter, output register
    rld_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .i_out_ready  (i_out_ready),
        .o_stat       (w_stat),
        .o_out_valid  (o_out_valid),
        .o_out_byte_a (o_out_byte_a),
        .o_out_byte_b (o_out_byte_b),
        .o_out_count  (o_out_count),
        .o_run_last   (o_run_last),
        .o_status     (o_status)
    );

    // taking a byte and stepping a run never overlap
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.take && w_cmd.step))
        else $error("take and step asserted together");

    // a run step follows a repeat byte only
    a_step_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step |-> w_stat.mode_rep)
        else $error("run step outside repeat mode");

    // an empty result is always the last one of its input
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_count == 2'd0) |-> o_run_last)
        else $error("empty result without run_last");

    // neither a take nor a run step overwrites a loaded result while stalled
    a_step_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.step || w_cmd.take) |-> (!o_out_valid || i_out_ready))
        else $error("output register overwritten while stalled");

endmodule

/* bench/run_length_decoder_tb.sv */
`timescale 1ns / 1ps

module run_length_decoder_tb;

    // longest stretch without any transfer before the run is declared hung;
    // a correct run never idles longer than a sender gap or a receiver stall
    // plus the pipeline delay
    localparam int IDLE_LIMIT = 400;
    // cycles allowed after the last expected result for stray output
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 280;
    localparam int MAX_WAIT = 18;

    // one encoded byte waiting to be sent, with the gap that precedes it
    typedef struct {
        logic [7:0]  data;
        logic        last;
        int unsigned gap;
    } t_src_item;

    // one decoded result as the block should present it
    typedef struct packed {
        logic [7:0]       byte_a;
        logic [7:0]       byte_b;
        logic [1:0]       count;
        logic             run_last;
        rld_pkg::t_status status;
    } t_decoded;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_in_byte = 8'd0;
    logic       i_in_last = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_out_byte_a;
    logic [7:0] o_out_byte_b;
    logic [1:0] o_out_count;
    logic       o_run_last;
    logic [1:0] o_status;

    t_src_item src_items[$];     // encoded bytes not yet transferred
    t_decoded  owed_results[$];  // decoded results still to come out

    // decoder state as predicted by the bench
    rld_pkg::t_mode dec_mode = rld_pkg::MODE_LEN;
    logic [7:0]     dec_left = 8'd0;

    // gap policy of the sender while the stimulus is being built
    bit tx_calm;

    int unsigned tx_wait;
    int unsigned rx_wait;
    int unsigned rx_calm_left;
    int unsigned idle_cycles;
    int          n_fail;
    int          n_sent;
    int          n_checked;
    int          n_queued;
    int          n_lit_bytes;
    int          n_rep_runs;
    int          n_eod;
    int          n_clean;
    int          n_trunc;

    run_length_decoder u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte_a (o_out_byte_a),
        .o_out_byte_b (o_out_byte_b),
        .o_out_count  (o_out_count),
        .o_run_last   (o_run_last),
        .o_status     (o_status)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_decoded make_result(input logic [7:0] a, input logic [7:0] b,
                                             input logic [1:0] cnt,
                                             input rld_pkg::t_status st);
        t_decoded r;
        r.byte_a   = a;
        r.byte_b   = b;
        r.count    = cnt;
        r.run_last = 1'b0;
        r.status   = st;
        return r;
    endfunction

    // advance the predicted decoder by one encoded byte and queue what it emits
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        t_decoded         made[$];
        logic [7:0]       take;
        rld_pkg::t_status end_st;
        case (dec_mode)
            rld_pkg::MODE_LEN: begin
                if (b < rld_pkg::EOD_CODE) begin
                    dec_mode = rld_pkg::MODE_LIT;
                    dec_left = b + 8'd1;
                end else if (b > rld_pkg::EOD_CODE) begin
                    dec_mode = rld_pkg::MODE_REP;
                    dec_left = 8'(rld_pkg::REP_BASE - {1'b0, b});
                    n_rep_runs++;
                end else begin
                    dec_mode = rld_pkg::MODE_EOD;
                    dec_left = 8'd0;
                    made.push_back(make_result(8'd0, 8'd0, 2'd0, rld_pkg::STATUS_EOD));
                    n_eod++;
                end
            end
            rld_pkg::MODE_LIT: begin
                made.push_back(make_result(b, 8'd0, 2'd1, rld_pkg::STATUS_DATA));
                n_lit_bytes++;
                if (dec_left != 8'd0)
                    dec_left = dec_left - 8'd1;
                if (dec_left == 8'd0)
                    dec_mode = rld_pkg::MODE_LEN;
            end
            rld_pkg::MODE_REP: begin
                // the run goes out two bytes at a time, odd tail last
                while (dec_left != 8'd0) begin
                    take = (dec_left >= rld_pkg::CHUNK) ? rld_pkg::CHUNK : dec_left;
                    made.push_back(make_result(b, (take == rld_pkg::CHUNK) ? b : 8'd0,
                                               take[1:0], rld_pkg::STATUS_DATA));
                    dec_left = dec_left - take;
                end
                dec_mode = rld_pkg::MODE_LEN;
            end
            default: begin
                // after the end-of-data marker everything is skipped
            end
        endcase

        if (last) begin
            // a run that still owes bytes at the source end is truncated
            if (dec_left != 8'd0 &&
                (dec_mode == rld_pkg::MODE_LIT || dec_mode == rld_pkg::MODE_REP)) begin
                end_st = rld_pkg::STATUS_TRUNC;
                n_trunc++;
            end else begin
                end_st = rld_pkg::STATUS_CLEAN;
                n_clean++;
            end
            if (made.size() == 0)
                made.push_back(make_result(8'd0, 8'd0, 2'd0, end_st));
            else
                made[made.size() - 1].status = end_st;
            dec_mode = rld_pkg::MODE_LEN;
            dec_left = 8'd0;
        end

        if (made.size() > 0)
            made[made.size() - 1].run_last = 1'b1;
        foreach (made[k])
            owed_results.push_back(made[k]);
    endfunction

    function automatic void queue_byte(input logic [7:0] data, input logic last);
        t_src_item it;
        it.data = data;
        it.last = last;
        if (tx_calm || $urandom_range(0, 2) != 0)
            it.gap = 0;
        else
            it.gap = $urandom_range(0, MAX_WAIT);
        src_items.push_back(it);
        n_queued++;
    endfunction

    // one random encoded source: mostly well-formed runs, sometimes cut short
    // or plain noise; in_last marks its final byte
    function automatic void queue_source();
        logic [7:0] enc[$];
        int         runs;
        int         kind;
        int         len;
        int         cut;
        tx_calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 7) == 0) begin
            len = $urandom_range(1, 5);
            repeat (len)
                enc.push_back(8'($urandom));
        end else begin
            runs = $urandom_range(1, 6);
            for (int r = 0; r < runs; r++) begin
                kind = $urandom_range(0, 9);
                if (kind < 5) begin
                    // literal run, occasionally a long one
                    if ($urandom_range(0, 24) == 0)
                        len = $urandom_range(8, 127);
                    else
                        len = $urandom_range(0, 7);
                    enc.push_back(8'(len));
                    repeat (len + 1)
                        enc.push_back(8'($urandom));
                end else if (kind < 9) begin
                    enc.push_back(8'($urandom_range(129, 255)));
                    enc.push_back(8'($urandom));
                end else begin
                    // end-of-data marker followed by a few skipped bytes
                    enc.push_back(rld_pkg::EOD_CODE);
                    repeat ($urandom_range(0, 3))
                        enc.push_back(8'($urandom));
                    break;
                end
            end
            if ($urandom_range(0, 5) == 0) begin
                cut = $urandom_range(1, enc.size());
                while (enc.size() > cut)
                    void'(enc.pop_back());
            end
        end
        foreach (enc[k])
            queue_byte(enc[k], k == enc.size() - 1);
    endfunction

    // sender: presents src_items in order, honoring each item's gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_wait    <= 0;
        end else if (i_in_valid && o_in_ready) begin
            decode_byte(i_in_byte, i_in_last);
            void'(src_items.pop_front());
            n_sent++;
            if (src_items.size() > 0 && src_items[0].gap == 0) begin
                // back-to-back transfer, valid stays high
                i_in_byte <= src_items[0].data;
                i_in_last <= src_items[0].last;
            end else begin
                i_in_valid <= 1'b0;
                if (src_items.size() > 0)
                    tx_wait <= src_items[0].gap - 1;
            end
        end else if (!i_in_valid && src_items.size() > 0) begin
            if (tx_wait == 0) begin
                i_in_valid <= 1'b1;
                i_in_byte  <= src_items[0].data;
                i_in_last  <= src_items[0].last;
            end else begin
                tx_wait <= tx_wait - 1;
            end
        end
    end

    // receiver: checks every result transfer and stalls at random between them
    always @(posedge i_clk) begin : rx_side
        t_decoded    want;
        int unsigned stall;
        if (!i_rst_n) begin
            i_out_ready  <= 1'b1;
            rx_wait      <= 0;
            rx_calm_left <= 0;
        end else if (o_out_valid && i_out_ready) begin
            n_checked++;
            if (owed_results.size() == 0) begin
                $error("unexpected result: byte_a %0d byte_b %0d count %0d status %0d",
                       o_out_byte_a, o_out_byte_b, o_out_count, o_status);
                n_fail++;
            end else begin
                want = owed_results.pop_front();
                if (o_out_byte_a !== want.byte_a) begin
                    $error("out_byte_a: expected %0d, got %0d", want.byte_a, o_out_byte_a);
                    n_fail++;
                end
                if (o_out_byte_b !== want.byte_b) begin
                    $error("out_byte_b: expected %0d, got %0d", want.byte_b, o_out_byte_b);
                    n_fail++;
                end
                if (o_out_count !== want.count) begin
                    $error("out_count: expected %0d, got %0d", want.count, o_out_count);
                    n_fail++;
                end
                if (o_run_last !== want.run_last) begin
                    $error("run_last: expected %0d, got %0d", want.run_last, o_run_last);
                    n_fail++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    n_fail++;
                end
            end
            // stretches with no stalls alternate with randomly stalled ones
            if (rx_calm_left > 0) begin
                rx_calm_left <= rx_calm_left - 1;
                stall = 0;
            end else if ($urandom_range(0, 15) == 0) begin
                rx_calm_left <= $urandom_range(10, 60);
                stall = 0;
            end else if ($urandom_range(0, 2) == 0) begin
                stall = $urandom_range(0, MAX_WAIT);
            end else begin
                stall = 0;
            end
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                rx_wait     <= stall - 1;
            end
        end else if (!i_out_ready) begin
            if (rx_wait == 0)
                i_out_ready <= 1'b1;
            else
                rx_wait <= rx_wait - 1;
        end
    end

    // watchdog: too long without any transfer on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("run_length_decoder test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int directed_items;
        tx_calm = 1'b0;

        // single literal with the top byte value
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        // three literals spanning low, mid and mixed bits
        queue_byte(8'h02, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h5A, 1'b0);
        // shortest repeat, longest repeat (64 results), odd-length repeat
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hA5, 1'b0);
        queue_byte(8'h81, 1'b0);
        queue_byte(8'h3C, 1'b0);
        queue_byte(8'hFE, 1'b0);
        queue_byte(8'h00, 1'b0);
        // longest literal length with the source ending on it: truncated
        queue_byte(8'h7F, 1'b1);
        // end-of-data marker, skipped bytes, then the source end
        queue_byte(rld_pkg::EOD_CODE, 1'b0);
        queue_byte(8'h12, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        // repeat length as the final byte: truncated
        queue_byte(8'hC0, 1'b1);
        // literal run ending exactly at the source end
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h11, 1'b0);
        queue_byte(8'h22, 1'b1);
        // repeat run ending exactly at the source end
        queue_byte(8'hFD, 1'b0);
        queue_byte(8'h77, 1'b1);
        // end-of-data marker that is also the final byte
        queue_byte(rld_pkg::EOD_CODE, 1'b1);
        // source ending in the middle of a literal run
        queue_byte(8'h05, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h02, 1'b1);
        directed_items = n_queued;

        while (n_queued < directed_items + RANDOM_ITEMS)
            queue_source();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (src_items.size() > 0 || owed_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d encoded bytes, checked %0d results, %0d failures",
                 n_sent, n_checked, n_fail);
        $display("literal bytes %0d, repeat runs %0d, eod markers %0d, clean ends %0d, %s %0d",
                 n_lit_bytes, n_rep_runs, n_eod, n_clean, "truncated ends", n_trunc);
        if (n_fail == 0 && owed_results.size() == 0)
            $display("run_length_decoder test passed");
        else
            $display("run_length_decoder test failed");
        $finish;
    end

endmodule
